### rtl/nested_loop_address_generator_unit_macros.svh
// Assertion macros shared by the RTL. The clock is clk and the reset is rst_n.
`ifndef NESTED_LOOP_ADDRESS_GENERATOR_UNIT_MACROS_SVH
`define NESTED_LOOP_ADDRESS_GENERATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NLAG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NLAG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/nlag_pkg.sv
package nlag_pkg;

    localparam int ADDR_BITS_DEF  = 11;
    localparam int COUNT_BITS_DEF = 10;

    localparam int STEP_BITS      = 12;
    localparam int LOOP_BITS      = 10;
    localparam int OUTER_BITS     = 20;
    localparam int CFG_DATA_BITS  = 20;
    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_INNER_INCREMENT  = 3'd0,
        REG_INNER_SHIFT      = 3'd1,
        REG_INNER_PERIOD     = 3'd2,
        REG_INNER_DUTY       = 3'd3,
        REG_INNER_ITERATIONS = 3'd4,
        REG_OUTER_INCREMENT  = 3'd5,
        REG_OUTER_SHIFT      = 3'd6,
        REG_OUTER_COUNTS     = 3'd7
    } cfg_index_t;

    typedef enum logic {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } op_t;

    typedef struct packed {
        logic signed [STEP_BITS-1:0] inner_increment;
        logic signed [STEP_BITS-1:0] inner_shift;
        logic [LOOP_BITS-1:0]        inner_period;
        logic [LOOP_BITS-1:0]        inner_duty;
        logic [LOOP_BITS-1:0]        inner_iterations;
        logic signed [STEP_BITS-1:0] outer_increment;
        logic signed [STEP_BITS-1:0] outer_shift;
        logic [LOOP_BITS-1:0]        outer_iterations;
        logic [LOOP_BITS-1:0]        outer_period;
    } cfg_t;

    typedef struct packed {
        logic enable;
        logic done;
        logic waiting;
    } flags_t;

endpackage

### rtl/nested_loop_address_generator_unit.sv
// Nested-loop strided address generator. A start beat (tuser low) loads the base address and
// the start delay; every tick beat (tuser high) spends one delay count or, until the run is
// done, steps the loop nest once, and returns the last generated address with enable, done
// and waiting flags. Exactly one result beat leaves for each input beat, in order. A beat is
// held in the input register until it is processed, and its result then waits in the result
// register; the loop state is computed combinationally and registered as the beat is
// processed, so one beat per clock is sustained while the result output is not stalled.
// Configuration writes take effect at once and belong to times when no beat is in flight.
`include "nested_loop_address_generator_unit_macros.svh"

module nested_loop_address_generator_unit #(
    parameter int ADDR_BITS  = nlag_pkg::ADDR_BITS_DEF,
    parameter int COUNT_BITS = nlag_pkg::COUNT_BITS_DEF,
    localparam int S_DATA_BITS = ((ADDR_BITS + nlag_pkg::LOOP_BITS + 7) / 8) * 8,
    localparam int M_DATA_BITS = ((ADDR_BITS + 3 + 7) / 8) * 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [nlag_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [nlag_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // start_address, start_delay, zero fill
    input  logic [S_DATA_BITS-1:0]              s_axis_tdata,
    // operation
    input  logic [0:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // address, enable, done_res, waiting, zero fill
    output logic [M_DATA_BITS-1:0]              m_axis_tdata
);

    nlag_pkg::cfg_t cfg_reg;

    logic                           in_valid_reg;
    nlag_pkg::op_t                  op_reg;
    logic [ADDR_BITS-1:0]           start_address_reg;
    logic [nlag_pkg::LOOP_BITS-1:0] start_delay_reg;

    logic                           out_valid_reg;
    logic [ADDR_BITS-1:0]           address_reg;
    nlag_pkg::flags_t               flags_reg;

    logic                           out_ready;
    logic                           fire;
    logic [ADDR_BITS-1:0]           res_address;
    nlag_pkg::flags_t               res_flags;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && out_ready;
    assign s_axis_tready = !in_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                nlag_pkg::REG_INNER_INCREMENT:
                    cfg_reg.inner_increment <= cfg_data[nlag_pkg::STEP_BITS-1:0];
                nlag_pkg::REG_INNER_SHIFT:
                    cfg_reg.inner_shift <= cfg_data[nlag_pkg::STEP_BITS-1:0];
                nlag_pkg::REG_INNER_PERIOD:
                    cfg_reg.inner_period <= cfg_data[nlag_pkg::LOOP_BITS-1:0];
                nlag_pkg::REG_INNER_DUTY:
                    cfg_reg.inner_duty <= cfg_data[nlag_pkg::LOOP_BITS-1:0];
                nlag_pkg::REG_INNER_ITERATIONS:
                    cfg_reg.inner_iterations <= cfg_data[nlag_pkg::LOOP_BITS-1:0];
                nlag_pkg::REG_OUTER_INCREMENT:
                    cfg_reg.outer_increment <= cfg_data[nlag_pkg::STEP_BITS-1:0];
                nlag_pkg::REG_OUTER_SHIFT:
                    cfg_reg.outer_shift <= cfg_data[nlag_pkg::STEP_BITS-1:0];
                nlag_pkg::REG_OUTER_COUNTS:
                begin
                    cfg_reg.outer_period     <= cfg_data[nlag_pkg::LOOP_BITS-1:0];
                    cfg_reg.outer_iterations <= cfg_data[nlag_pkg::OUTER_BITS-1:
                                                         nlag_pkg::LOOP_BITS];
                end
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
        else if (fire && (op_reg == nlag_pkg::OP_START) && (cfg_reg.inner_duty == '0))
        begin
            // A zero duty means the whole period; the start makes that substitution stick.
            cfg_reg.inner_duty <= cfg_reg.inner_period;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            op_reg            <= nlag_pkg::op_t'(s_axis_tuser[0]);
            start_address_reg <= s_axis_tdata[ADDR_BITS-1:0];
            start_delay_reg   <= s_axis_tdata[ADDR_BITS+nlag_pkg::LOOP_BITS-1:ADDR_BITS];
        end
        if (fire)
        begin
            address_reg <= res_address;
            flags_reg   <= res_flags;
        end
    end

    nlag_engine #(
        .ADDR_BITS  (ADDR_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .fire          (fire),
        .op            (op_reg),
        .start_address (start_address_reg),
        .start_delay   (start_delay_reg),
        .res_address   (res_address),
        .res_flags     (res_flags)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_DATA_BITS'({flags_reg.waiting, flags_reg.done,
                                         flags_reg.enable, address_reg});

    `NLAG_ASSERT_NOW(a_stall_only_when_full, !s_axis_tready, in_valid_reg, "input stalled with an empty input register")
    `NLAG_ASSERT_NEXT(a_item_gives_result, fire, out_valid_reg, "processed beat produced no result")
    `NLAG_ASSERT_NOW(a_wait_without_enable, out_valid_reg, !(flags_reg.waiting && flags_reg.enable), "result both waiting and enabled")

endmodule

### rtl/nlag_engine.sv
`include "nested_loop_address_generator_unit_macros.svh"

module nlag_engine #(
    parameter int ADDR_BITS  = nlag_pkg::ADDR_BITS_DEF,
    parameter int COUNT_BITS = nlag_pkg::COUNT_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  nlag_pkg::cfg_t                 cfg,
    input  logic                           fire,
    input  nlag_pkg::op_t                  op,
    input  logic [ADDR_BITS-1:0]           start_address,
    input  logic [nlag_pkg::LOOP_BITS-1:0] start_delay,
    output logic [ADDR_BITS-1:0]           res_address,
    output nlag_pkg::flags_t               res_flags
);

    localparam int CMP_BITS = (COUNT_BITS > nlag_pkg::LOOP_BITS) ? COUNT_BITS
                                                                 : nlag_pkg::LOOP_BITS;

    function automatic logic [ADDR_BITS-1:0] step_addr(
        input logic [ADDR_BITS-1:0]                  a,
        input logic signed [nlag_pkg::STEP_BITS-1:0] d
    );
        logic signed [ADDR_BITS+nlag_pkg::STEP_BITS-1:0] ext;
        ext = (ADDR_BITS + nlag_pkg::STEP_BITS)'(d);
        return a + ext[ADDR_BITS-1:0];
    endfunction

    logic [ADDR_BITS-1:0]  cp_reg, cp_next;
    logic [ADDR_BITS-1:0]  ob_reg, ob_next;
    logic [ADDR_BITS-1:0]  bc_reg, bc_next;
    logic [ADDR_BITS-1:0]  la_reg, la_next;
    logic [COUNT_BITS-1:0] pc_reg, pc_next;
    logic [COUNT_BITS-1:0] ic_reg, ic_next;
    logic [COUNT_BITS-1:0] opc_reg, opc_next;
    logic [COUNT_BITS-1:0] oic_reg, oic_next;
    logic [COUNT_BITS-1:0] dc_reg, dc_next;
    logic [COUNT_BITS-1:0] dl_reg, dl_next;
    logic                  en_reg, en_next;
    logic                  done_reg, done_next;

    logic [COUNT_BITS-1:0] delay_load;
    logic [CMP_BITS-1:0]   per_x, duty_x, iters_x, per2_x, iter2_x;
    logic                  two_level;
    logic                  do_inner;
    logic                  res_en;
    logic                  res_wait;

    assign delay_load = COUNT_BITS'(start_delay);
    assign per_x      = CMP_BITS'(cfg.inner_period);
    assign duty_x     = CMP_BITS'(cfg.inner_duty);
    assign iters_x    = CMP_BITS'(cfg.inner_iterations);
    assign per2_x     = CMP_BITS'(cfg.outer_period);
    assign iter2_x    = CMP_BITS'(cfg.outer_iterations);
    assign two_level  = (cfg.outer_period == '0) && (cfg.outer_iterations == '0);

    // The inner loop steps only while every enclosing level is still below its bound.
    always_comb
    begin
        if (two_level)
        begin
            do_inner = CMP_BITS'(ic_reg) < iters_x;
        end
        else
        begin
            do_inner = (CMP_BITS'(oic_reg) < iter2_x) && (CMP_BITS'(opc_reg) < per2_x)
                       && (CMP_BITS'(ic_reg) < iters_x);
        end
    end

    always_comb
    begin
        cp_next   = cp_reg;
        ob_next   = ob_reg;
        bc_next   = bc_reg;
        la_next   = la_reg;
        pc_next   = pc_reg;
        ic_next   = ic_reg;
        opc_next  = opc_reg;
        oic_next  = oic_reg;
        dc_next   = dc_reg;
        dl_next   = dl_reg;
        en_next   = en_reg;
        done_next = done_reg;
        res_en    = 1'b0;
        res_wait  = 1'b0;
        if (fire)
        begin
            if (op == nlag_pkg::OP_START)
            begin
                bc_next   = start_address;
                cp_next   = start_address;
                ob_next   = start_address;
                dl_next   = delay_load;
                pc_next   = '0;
                ic_next   = '0;
                opc_next  = '0;
                oic_next  = '0;
                dc_next   = '0;
                en_next   = 1'b0;
                done_next = 1'b0;
                res_wait  = delay_load != '0;
            end
            else if (dl_reg != '0)
            begin
                dl_next  = dl_reg - 1'b1;
                res_wait = 1'b1;
            end
            else if (!done_reg)
            begin
                if (do_inner)
                begin
                    if (CMP_BITS'(pc_next) < per_x)
                    begin
                        pc_next = pc_next + 1'b1;
                        en_next = 1'b0;
                        if (CMP_BITS'(dc_next) < duty_x)
                        begin
                            en_next = 1'b1;
                            la_next = cp_next;
                            dc_next = dc_next + 1'b1;
                            cp_next = step_addr(cp_next, cfg.inner_increment);
                        end
                    end
                    if (CMP_BITS'(pc_next) == per_x)
                    begin
                        pc_next = '0;
                        dc_next = '0;
                        ic_next = ic_next + 1'b1;
                        cp_next = step_addr(cp_next, cfg.inner_shift);
                    end
                end
                if (two_level)
                begin
                    if (CMP_BITS'(ic_next) == iters_x)
                    begin
                        ic_next   = '0;
                        done_next = 1'b1;
                    end
                end
                else
                begin
                    if (CMP_BITS'(oic_next) < iter2_x)
                    begin
                        if (CMP_BITS'(opc_next) < per2_x)
                        begin
                            if (CMP_BITS'(ic_next) == iters_x)
                            begin
                                ic_next  = '0;
                                ob_next  = step_addr(ob_next, cfg.outer_increment);
                                cp_next  = ob_next;
                                opc_next = opc_next + 1'b1;
                            end
                        end
                        if (CMP_BITS'(opc_next) == per2_x)
                        begin
                            ob_next  = step_addr(ob_next, cfg.outer_shift);
                            cp_next  = ob_next;
                            opc_next = '0;
                            oic_next = oic_next + 1'b1;
                        end
                    end
                    if (CMP_BITS'(oic_next) == iter2_x)
                    begin
                        done_next = 1'b1;
                    end
                end
                if (done_next)
                begin
                    cp_next = bc_next;
                    ob_next = bc_next;
                end
                res_en = en_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cp_reg   <= '0;
            ob_reg   <= '0;
            bc_reg   <= '0;
            la_reg   <= '0;
            pc_reg   <= '0;
            ic_reg   <= '0;
            opc_reg  <= '0;
            oic_reg  <= '0;
            dc_reg   <= '0;
            dl_reg   <= '0;
            en_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cp_reg   <= cp_next;
            ob_reg   <= ob_next;
            bc_reg   <= bc_next;
            la_reg   <= la_next;
            pc_reg   <= pc_next;
            ic_reg   <= ic_next;
            opc_reg  <= opc_next;
            oic_reg  <= oic_next;
            dc_reg   <= dc_next;
            dl_reg   <= dl_next;
            en_reg   <= en_next;
            done_reg <= done_next;
        end
    end

    assign res_address       = la_next;
    assign res_flags.enable  = res_en;
    assign res_flags.done    = done_next;
    assign res_flags.waiting = res_wait;

    `NLAG_ASSERT_NOW(a_done_parks_at_base, done_reg, (cp_reg == bc_reg) && (ob_reg == bc_reg), "finished run left the position off its base")
    `NLAG_ASSERT_NEXT(a_delay_freezes_nest, fire && (op == nlag_pkg::OP_TICK) && (dl_reg != '0), $stable(la_reg) && $stable(pc_reg) && $stable(ic_reg), "loop nest moved during start delay")

endmodule

### tb/nested_loop_address_generator_unit_tb.sv
module nested_loop_address_generator_unit_tb;

    localparam int LIMIT_CYCLES = 400000;
    localparam int LONG_HOLD    = 250;
    localparam int TARGET_BEATS = 800;
    localparam int QUIET_BEATS  = 650;

    typedef struct packed {
        logic [10:0] address;
        logic        enable;
        logic        done;
        logic        waiting;
    } gen_result_t;

    class addr_gen_scoreboard;
        logic [11:0] inner_inc;
        logic [11:0] inner_shift;
        logic [9:0]  inner_period;
        logic [9:0]  inner_duty;
        logic [9:0]  inner_iters;
        logic [11:0] outer_inc;
        logic [11:0] outer_shift;
        logic [19:0] outer_counts;

        logic [10:0] position;
        logic [10:0] outer_base;
        logic [10:0] base_copy;
        logic [10:0] last_addr;
        logic [9:0]  period_cnt;
        logic [9:0]  iter_cnt;
        logic [9:0]  outer_period_cnt;
        logic [9:0]  outer_iter_cnt;
        logic [9:0]  duty_used;
        logic [9:0]  delay_left;
        logic        enable_flag;
        logic        done_flag;

        gen_result_t expected_beats[$];
        int          errors;

        function new();
            inner_inc = '0;
            inner_shift = '0;
            inner_period = '0;
            inner_duty = '0;
            inner_iters = '0;
            outer_inc = '0;
            outer_shift = '0;
            outer_counts = '0;
            position = '0;
            outer_base = '0;
            base_copy = '0;
            last_addr = '0;
            period_cnt = '0;
            iter_cnt = '0;
            outer_period_cnt = '0;
            outer_iter_cnt = '0;
            duty_used = '0;
            delay_left = '0;
            enable_flag = 1'b0;
            done_flag = 1'b0;
            errors = 0;
        endfunction

        function void set_register(nlag_pkg::cfg_index_t idx, logic [19:0] value);
            case (idx)
                nlag_pkg::REG_INNER_INCREMENT:  inner_inc = value[11:0];
                nlag_pkg::REG_INNER_SHIFT:      inner_shift = value[11:0];
                nlag_pkg::REG_INNER_PERIOD:     inner_period = value[9:0];
                nlag_pkg::REG_INNER_DUTY:       inner_duty = value[9:0];
                nlag_pkg::REG_INNER_ITERATIONS: inner_iters = value[9:0];
                nlag_pkg::REG_OUTER_INCREMENT:  outer_inc = value[11:0];
                nlag_pkg::REG_OUTER_SHIFT:      outer_shift = value[11:0];
                nlag_pkg::REG_OUTER_COUNTS:     outer_counts = value;
                default:                        ;
            endcase
        endfunction

        // Only the low address bits of the signed step matter after the wrap.
        function logic [10:0] stepped(logic [10:0] a, logic [11:0] s);
            return a + s[10:0];
        endfunction

        function void period_step();
            if (period_cnt < inner_period)
            begin
                period_cnt = period_cnt + 10'd1;
                enable_flag = 1'b0;
                if (duty_used < inner_duty)
                begin
                    enable_flag = 1'b1;
                    last_addr = position;
                    duty_used = duty_used + 10'd1;
                    position = stepped(position, inner_inc);
                end
            end
            if (period_cnt == inner_period)
            begin
                period_cnt = '0;
                duty_used = '0;
                iter_cnt = iter_cnt + 10'd1;
                position = stepped(position, inner_shift);
            end
        endfunction

        function void nest_step();
            logic [9:0] outer_per;
            logic [9:0] outer_its;
            outer_per = outer_counts[9:0];
            outer_its = outer_counts[19:10];
            if (outer_per == 0 && outer_its == 0)
            begin
                if (iter_cnt < inner_iters)
                    period_step();
                if (iter_cnt == inner_iters)
                begin
                    iter_cnt = '0;
                    done_flag = 1'b1;
                end
            end
            else
            begin
                if (outer_iter_cnt < outer_its)
                begin
                    if (outer_period_cnt < outer_per)
                    begin
                        if (iter_cnt < inner_iters)
                            period_step();
                        if (iter_cnt == inner_iters)
                        begin
                            iter_cnt = '0;
                            outer_base = stepped(outer_base, outer_inc);
                            position = outer_base;
                            outer_period_cnt = outer_period_cnt + 10'd1;
                        end
                    end
                    if (outer_period_cnt == outer_per)
                    begin
                        outer_base = stepped(outer_base, outer_shift);
                        position = outer_base;
                        outer_period_cnt = '0;
                        outer_iter_cnt = outer_iter_cnt + 10'd1;
                    end
                end
                if (outer_iter_cnt == outer_its)
                    done_flag = 1'b1;
            end
            if (done_flag)
            begin
                position = base_copy;
                outer_base = base_copy;
            end
        endfunction

        function void note_input(nlag_pkg::op_t op, logic [10:0] addr, logic [9:0] dly);
            gen_result_t r;
            r.enable = 1'b0;
            r.waiting = 1'b0;
            if (op == nlag_pkg::OP_START)
            begin
                base_copy = addr;
                position = addr;
                outer_base = addr;
                delay_left = dly;
                period_cnt = '0;
                iter_cnt = '0;
                outer_period_cnt = '0;
                outer_iter_cnt = '0;
                duty_used = '0;
                enable_flag = 1'b0;
                done_flag = 1'b0;
                // A zero duty is replaced in the register by the full period.
                if (inner_duty == 0)
                    inner_duty = inner_period;
                r.waiting = (dly != 0);
            end
            else if (delay_left != 0)
            begin
                delay_left = delay_left - 10'd1;
                r.waiting = 1'b1;
            end
            else if (!done_flag)
            begin
                nest_step();
                r.enable = enable_flag;
            end
            r.address = last_addr;
            r.done = done_flag;
            expected_beats.push_back(r);
        endfunction

        function void check_result(logic [15:0] beat);
            gen_result_t exp_r;
            if (expected_beats.size() == 0)
            begin
                $error("result beat 0x%04h arrived with nothing expected", beat);
                errors++;
                return;
            end
            exp_r = expected_beats.pop_front();
            if (beat[10:0] !== exp_r.address)
            begin
                $error("address: expected %0d, actual %0d", exp_r.address, beat[10:0]);
                errors++;
            end
            if (beat[11] !== exp_r.enable)
            begin
                $error("enable: expected %0d, actual %0d", exp_r.enable, beat[11]);
                errors++;
            end
            if (beat[12] !== exp_r.done)
            begin
                $error("done_res: expected %0d, actual %0d", exp_r.done, beat[12]);
                errors++;
            end
            if (beat[13] !== exp_r.waiting)
            begin
                $error("waiting: expected %0d, actual %0d", exp_r.waiting, beat[13]);
                errors++;
            end
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [19:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // start_address [10:0], start_delay [20:11], zero fill [23:21]
    logic [23:0] s_axis_tdata;
    // operation [0]
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // address [10:0], enable [11], done_res [12], waiting [13], zero fill [15:14]
    logic [15:0] m_axis_tdata;

    addr_gen_scoreboard sb;
    logic [19:0]        reg_val [8];
    bit                 quiet;
    bit                 hold_long;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 beats_sent;
    int                 cycles;

    nested_loop_address_generator_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    initial
    begin : result_sink
        int burst;
        m_axis_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_long)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_long = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 99) < recv_idle_pct)
            begin
                burst = $urandom_range(1, 18);
                m_axis_tready <= 1'b0;
                repeat (burst) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic send_beat(input nlag_pkg::op_t op, input logic [10:0] addr,
                             input logic [9:0] dly);
        int gap;
        if (!quiet && $urandom_range(0, 99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 18);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, dly, addr};
        s_axis_tuser <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_input(op, addr, dly);
        beats_sent++;
    endtask

    task automatic send_tick();
        send_beat(nlag_pkg::OP_TICK, 11'($urandom_range(0, 2047)),
                  10'($urandom_range(0, 1023)));
    endtask

    // Ticks until the run completes, at most the given number of ticks.
    task automatic tick_until_done(input int cap);
        int n;
        n = 0;
        while (n < cap && !(sb.done_flag && sb.delay_left == 0))
        begin
            send_tick();
            n++;
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic program_regs(input bit write_all);
        nlag_pkg::cfg_index_t idx;
        int wrote;
        wrote = 0;
        for (int i = 0; i < 8; i++)
        begin
            if (write_all || $urandom_range(0, 1) == 1 || (i == 7 && wrote == 0))
            begin
                idx = nlag_pkg::cfg_index_t'(i);
                cfg_we <= 1'b1;
                cfg_index <= idx;
                cfg_data <= reg_val[i];
                @(posedge clk);
                sb.set_register(idx, reg_val[i]);
                wrote++;
            end
        end
        cfg_we <= 1'b0;
    endtask

    task automatic pick_regs();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode == 0)
        begin
            reg_val[nlag_pkg::REG_INNER_INCREMENT] = $urandom_range(0, 1) ? 20'h007FF : 20'h00800;
            reg_val[nlag_pkg::REG_INNER_SHIFT] = $urandom_range(0, 1) ? 20'h007FF : 20'h00800;
            reg_val[nlag_pkg::REG_INNER_PERIOD] = 20'd1023;
            reg_val[nlag_pkg::REG_INNER_DUTY] = $urandom_range(0, 1) ? 20'd1023 : 20'd0;
            reg_val[nlag_pkg::REG_INNER_ITERATIONS] = 20'd1023;
            reg_val[nlag_pkg::REG_OUTER_INCREMENT] = $urandom_range(0, 1) ? 20'h007FF : 20'h00800;
            reg_val[nlag_pkg::REG_OUTER_SHIFT] = $urandom_range(0, 1) ? 20'h007FF : 20'h00800;
            reg_val[nlag_pkg::REG_OUTER_COUNTS] = $urandom_range(0, 1) ? 20'hFFFFF : 20'h00000;
        end
        else if (mode == 1)
        begin
            for (int i = 0; i < 8; i++)
                reg_val[i] = '0;
        end
        else
        begin
            reg_val[nlag_pkg::REG_INNER_INCREMENT] = 20'($urandom_range(0, 4095));
            reg_val[nlag_pkg::REG_INNER_SHIFT] = 20'($urandom_range(0, 4095));
            reg_val[nlag_pkg::REG_INNER_PERIOD] = 20'($urandom_range(0, 5));
            reg_val[nlag_pkg::REG_INNER_DUTY] = 20'($urandom_range(0, 6));
            reg_val[nlag_pkg::REG_INNER_ITERATIONS] = 20'($urandom_range(0, 4));
            reg_val[nlag_pkg::REG_OUTER_INCREMENT] = 20'($urandom_range(0, 4095));
            reg_val[nlag_pkg::REG_OUTER_SHIFT] = 20'($urandom_range(0, 4095));
            if ($urandom_range(0, 99) < 30)
                reg_val[nlag_pkg::REG_OUTER_COUNTS] = '0;
            else
                reg_val[nlag_pkg::REG_OUTER_COUNTS] = {10'($urandom_range(0, 3)),
                                                       10'($urandom_range(0, 3))};
        end
    endtask

    task automatic run_phase(input int runs, input bit carry_on);
        int pick;
        logic [9:0] dly;
        for (int r = 0; r < runs; r++)
        begin
            if (!(carry_on && r == 0))
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    dly = '0;
                else if (pick < 90)
                    dly = 10'($urandom_range(1, 4));
                else
                    dly = 10'($urandom_range(0, 1023));
                send_beat(nlag_pkg::OP_START, 11'($urandom_range(0, 2047)), dly);
            end
            // Some runs are cut short by the next start.
            if ($urandom_range(0, 9) == 0)
                tick_until_done($urandom_range(0, 6));
            else
                tick_until_done(60);
            repeat ($urandom_range(0, 3)) send_tick();
            if ($urandom_range(0, 9) == 0)
                drain();
        end
    endtask

    initial
    begin : stimulus
        int phase;
        int pct_pick [3];
        sb = new();
        pct_pick[0] = 0;
        pct_pick[1] = 10;
        pct_pick[2] = 35;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        quiet = 1'b0;
        hold_long = 1'b0;
        send_idle_pct = 20;
        recv_idle_pct = 20;
        beats_sent = 0;
        cycles = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Ticks straight out of reset finish at once on the zero registers.
        send_tick();
        send_tick();
        send_beat(nlag_pkg::OP_START, 11'd2047, 10'd0);
        send_tick();
        drain();

        reg_val[nlag_pkg::REG_INNER_INCREMENT] = 20'h007FF;
        reg_val[nlag_pkg::REG_INNER_SHIFT] = 20'h00800;
        reg_val[nlag_pkg::REG_INNER_PERIOD] = 20'd3;
        reg_val[nlag_pkg::REG_INNER_DUTY] = 20'd0;
        reg_val[nlag_pkg::REG_INNER_ITERATIONS] = 20'd2;
        reg_val[nlag_pkg::REG_OUTER_INCREMENT] = 20'h00800;
        reg_val[nlag_pkg::REG_OUTER_SHIFT] = 20'h007FF;
        reg_val[nlag_pkg::REG_OUTER_COUNTS] = 20'd0;
        program_regs(1'b1);
        send_beat(nlag_pkg::OP_START, 11'd0, 10'd2);
        tick_until_done(12);
        send_tick();
        send_beat(nlag_pkg::OP_START, 11'd1024, 10'd1023);
        send_tick();
        drain();

        reg_val[nlag_pkg::REG_INNER_PERIOD] = 20'd2;
        reg_val[nlag_pkg::REG_INNER_DUTY] = 20'd1;
        reg_val[nlag_pkg::REG_INNER_ITERATIONS] = 20'd1;
        reg_val[nlag_pkg::REG_OUTER_COUNTS] = {10'd1, 10'd2};
        program_regs(1'b1);
        send_beat(nlag_pkg::OP_START, 11'd5, 10'd0);
        tick_until_done(10);
        drain();

        phase = 0;
        while (beats_sent < TARGET_BEATS)
        begin
            if (beats_sent > QUIET_BEATS)
                quiet = 1'b1;
            send_idle_pct = pct_pick[$urandom_range(0, 2)];
            recv_idle_pct = pct_pick[$urandom_range(0, 2)];
            pick_regs();
            program_regs(phase < 2 || $urandom_range(0, 1) == 1);
            if (phase == 1)
            begin
                send_idle_pct = 0;
                hold_long = 1'b1;
            end
            run_phase($urandom_range(2, 6), phase > 0 && $urandom_range(0, 3) == 0);
            drain();
            phase++;
        end

        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/nlag_pkg.sv
rtl/nlag_engine.sv
rtl/nested_loop_address_generator_unit.sv
tb/nested_loop_address_generator_unit_tb.sv
